>>> hw/rtl/cpu0_pkg.sv
`timescale 1ns / 1ps

package cpu0_pkg;

    localparam int MemBytes    = 4096;
    localparam int MemAddrW    = $clog2(MemBytes);
    localparam int PcIndex     = 15;
    localparam int LrIndex     = 14;
    localparam int SpIndex     = 13;
    localparam int StatusIndex = 12;
    localparam int ArgIndex    = 9;

    localparam logic [3:0] PC_IDX  = 4'(PcIndex);
    localparam logic [3:0] LR_IDX  = 4'(LrIndex);
    localparam logic [3:0] SP_IDX  = 4'(SpIndex);
    localparam logic [3:0] ST_IDX  = 4'(StatusIndex);
    localparam logic [3:0] ARG_IDX = 4'(ArgIndex);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_EXEC  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] OP_LD   = 8'h00;
    localparam logic [7:0] OP_ST   = 8'h01;
    localparam logic [7:0] OP_LB   = 8'h02;
    localparam logic [7:0] OP_SB   = 8'h03;
    localparam logic [7:0] OP_LDR  = 8'h04;
    localparam logic [7:0] OP_STR  = 8'h05;
    localparam logic [7:0] OP_LBR  = 8'h06;
    localparam logic [7:0] OP_SBR  = 8'h07;
    localparam logic [7:0] OP_LDI  = 8'h08;
    localparam logic [7:0] OP_CMP  = 8'h10;
    localparam logic [7:0] OP_MOV  = 8'h12;
    localparam logic [7:0] OP_ADD  = 8'h13;
    localparam logic [7:0] OP_SUB  = 8'h14;
    localparam logic [7:0] OP_MUL  = 8'h15;
    localparam logic [7:0] OP_DIV  = 8'h16;
    localparam logic [7:0] OP_AND  = 8'h18;
    localparam logic [7:0] OP_OR   = 8'h19;
    localparam logic [7:0] OP_XOR  = 8'h1A;
    localparam logic [7:0] OP_ADDI = 8'h1B;
    localparam logic [7:0] OP_ROL  = 8'h1C;
    localparam logic [7:0] OP_ROR  = 8'h1D;
    localparam logic [7:0] OP_SHL  = 8'h1E;
    localparam logic [7:0] OP_SHR  = 8'h1F;
    localparam logic [7:0] OP_JEQ  = 8'h20;
    localparam logic [7:0] OP_JNE  = 8'h21;
    localparam logic [7:0] OP_JLT  = 8'h22;
    localparam logic [7:0] OP_JGT  = 8'h23;
    localparam logic [7:0] OP_JLE  = 8'h24;
    localparam logic [7:0] OP_JGE  = 8'h25;
    localparam logic [7:0] OP_JMP  = 8'h26;
    localparam logic [7:0] OP_SWI  = 8'h2A;
    localparam logic [7:0] OP_CALL = 8'h2B;
    localparam logic [7:0] OP_RET  = 8'h2C;
    localparam logic [7:0] OP_IRET = 8'h2D;
    localparam logic [7:0] OP_PUSH = 8'h30;
    localparam logic [7:0] OP_POP  = 8'h31;
    localparam logic [7:0] OP_PSHB = 8'h32;
    localparam logic [7:0] OP_POPB = 8'h33;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_EXEC,
        S_DIV,
        S_MEMRD,
        S_MEMWR,
        S_READ,
        S_DONE
    } t_state;

    // Request and status between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/cpu0_divider.sv
`timescale 1ns / 1ps

// Signed restoring divider, one quotient bit per cycle.
module cpu0_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpu0_pkg::t_div_req i_req,
    output cpu0_pkg::t_div_rsp o_rsp
);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_zero, n_zero;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = 32'd0;
            n_quo  = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
            n_den  = i_req.divisor[31] ? (32'd0 - i_req.divisor) : i_req.divisor;
            n_neg  = i_req.dividend[31] ^ i_req.divisor[31];
            n_zero = (i_req.divisor == 32'd0);
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_zero ? 32'd0 : (r_neg ? (32'd0 - r_quo) : r_quo);

endmodule

>>> hw/rtl/cpu0_instruction_executor_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Bits  Contents
// s_axis    in   48    tdata: action[1:0], mem_address[13:2], mem_data[45:14]
// m_axis    out   128  tdata: pc_value, halted, illegal_opcode, swi_event,
//                      swi_code, swi_value, read_word
//
// A request is served one at a time. Memory is byte-wide with registered read
// data, so a word is read or written one byte at a time. A memory write goes
// straight to the store state and a read to the read state; an instruction is
// fetched, decoded, and then may load or store a byte or a word, or wait on the
// serial divider for a divide. A halted execute or the unused action goes
// straight to the done state.
// Reset clears the registers and the halt flag; memory is not cleared.
// The result waits in its output register while the sink stalls; the next
// request is taken once that result has been taken.
module cpu0_instruction_executor_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: action[1:0], mem_address[13:2], mem_data[45:14], zeros above
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: pc_value[31:0], halted[32], illegal_opcode[33], swi_event[34],
    // swi_code[58:35], swi_value[90:59], read_word[122:91], zeros above
    output logic [127:0] m_axis_tdata
);

    localparam int AW = cpu0_pkg::MemAddrW;

    cpu0_pkg::t_state r_state, n_state;

    logic [7:0]  r_mem [cpu0_pkg::MemBytes];
    logic [31:0] r_rf [16];

    logic [AW-1:0] r_addr, n_addr;
    logic [31:0] r_data, n_data;
    logic [31:0] r_ir, n_ir;
    logic [1:0]  r_bcnt, n_bcnt;
    logic        r_word, n_word;
    logic [3:0]  r_dst, n_dst;
    logic        r_halt, n_halt;
    logic        r_ill, n_ill;
    logic        r_swi, n_swi;
    logic [23:0] r_code, n_code;
    logic [31:0] r_swiv, n_swiv;
    logic [31:0] r_rdw, n_rdw;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_rbyte;

    logic        w_mwe;
    logic [AW-1:0] w_maddr;
    logic [7:0]  w_mwd;
    logic        w_rwe;
    logic [3:0]  w_rwa;
    logic [31:0] w_rwd;
    logic        w_rwe2;
    logic [3:0]  w_rwa2;
    logic [31:0] w_rwd2;

    cpu0_pkg::t_div_req w_dreq;
    cpu0_pkg::t_div_rsp w_drsp;

    cpu0_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // Decoded instruction fields.
    logic [7:0]  w_op;
    logic [3:0]  w_ra, w_rb, w_rc;
    logic [31:0] w_c24, w_c16, w_va, w_vb, w_vc, w_st, w_pc;
    logic [4:0]  w_c5;

    always_comb begin
        w_op  = r_ir[31:24];
        w_ra  = r_ir[23:20];
        w_rb  = r_ir[19:16];
        w_rc  = r_ir[15:12];
        w_c24 = {{8{r_ir[23]}}, r_ir[23:0]};
        w_c16 = {{16{r_ir[15]}}, r_ir[15:0]};
        w_c5  = r_ir[4:0];
        w_va  = (w_ra == 4'd0) ? 32'd0 : r_rf[w_ra];
        w_vb  = (w_rb == 4'd0) ? 32'd0 : r_rf[w_rb];
        w_vc  = (w_rc == 4'd0) ? 32'd0 : r_rf[w_rc];
        w_st  = r_rf[cpu0_pkg::ST_IDX];
        w_pc  = r_rf[cpu0_pkg::PC_IDX];
    end

    // Byte memory, one access a cycle with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_mem[w_maddr] <= w_mwd;
        end
        r_rbyte <= r_mem[w_maddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_rf[i] <= 32'd0;
            end
        end else begin
            if (w_rwe) begin
                r_rf[w_rwa] <= w_rwd;
            end
            if (w_rwe2) begin
                r_rf[w_rwa2] <= w_rwd2;
            end
        end
    end

    always_comb begin
        logic        take;
        logic [32:0] cmp;
        logic [31:0] ea;
        logic [31:0] push_val;
        take = 1'b0;
        cmp  = 33'd0;
        ea   = 32'd0;
        push_val = 32'd0;
        n_state  = r_state;
        n_addr   = r_addr;
        n_data   = r_data;
        n_ir     = r_ir;
        n_bcnt   = r_bcnt;
        n_word   = r_word;
        n_dst    = r_dst;
        n_halt   = r_halt;
        n_ill    = r_ill;
        n_swi    = r_swi;
        n_code   = r_code;
        n_swiv   = r_swiv;
        n_rdw    = r_rdw;
        n_ovalid = r_ovalid;
        w_mwe    = 1'b0;
        w_maddr  = r_addr;
        w_mwd    = r_data[31:24];
        w_rwe    = 1'b0;
        w_rwa    = r_dst;
        w_rwd    = r_data;
        w_rwe2   = 1'b0;
        w_rwa2   = cpu0_pkg::SP_IDX;
        w_rwd2   = 32'd0;
        w_dreq.start    = 1'b0;
        w_dreq.dividend = w_vb;
        w_dreq.divisor  = w_vc;
        s_axis_tready = (r_state == cpu0_pkg::S_IDLE) && !r_ovalid;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            cpu0_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_addr = s_axis_tdata[2 +: AW];
                    n_data = s_axis_tdata[45:14];
                    n_ill  = 1'b0;
                    n_swi  = 1'b0;
                    n_code = 24'd0;
                    n_swiv = 32'd0;
                    n_rdw  = 32'd0;
                    n_bcnt = 2'd0;
                    n_word = 1'b1;
                    case (s_axis_tdata[1:0])
                        cpu0_pkg::ACT_WRITE: n_state = cpu0_pkg::S_MEMWR;
                        cpu0_pkg::ACT_READ:  n_state = cpu0_pkg::S_READ;
                        cpu0_pkg::ACT_EXEC: begin
                            if (r_halt) begin
                                n_state = cpu0_pkg::S_DONE;
                            end else begin
                                n_addr  = w_pc[AW-1:0];
                                n_state = cpu0_pkg::S_FETCH;
                            end
                        end
                        default: n_state = cpu0_pkg::S_DONE;
                    endcase
                end
            end
            // Reads four bytes into r_data, or a single byte for a byte load, from the registered memory read data.
            cpu0_pkg::S_FETCH, cpu0_pkg::S_READ, cpu0_pkg::S_MEMRD: begin
                w_maddr = r_addr;
                n_addr  = r_addr + AW'(1);
                n_bcnt  = r_bcnt + 2'd1;
                if (r_bcnt != 2'd0 || r_word == 1'b0) begin
                    n_data = {r_data[23:0], r_rbyte};
                end
                if (r_state == cpu0_pkg::S_MEMRD && !r_word) begin
                    n_bcnt = r_bcnt;
                    if (r_bcnt == 2'd1) begin
                        w_rwe = 1'b1;
                        w_rwd = {24'd0, r_rbyte};
                        // A byte pop into SP still leaves SP one past the byte.
                        if (w_op == cpu0_pkg::OP_POPB && r_dst == cpu0_pkg::SP_IDX) begin
                            w_rwd = {24'd0, r_rbyte} + 32'd1;
                        end
                        n_state = cpu0_pkg::S_DONE;
                    end else begin
                        n_bcnt = 2'd1;
                    end
                end else if (r_bcnt == 2'd3 && r_word) begin
                    n_word = 1'b0;
                    n_bcnt = 2'd3;
                end
                if (!r_word && r_bcnt == 2'd3) begin
                    n_data = {r_data[23:0], r_rbyte};
                    unique case (r_state)
                        cpu0_pkg::S_FETCH: begin
                            n_ir = {r_data[23:0], r_rbyte};
                            w_rwe = 1'b1;
                            w_rwa = cpu0_pkg::PC_IDX;
                            w_rwd = w_pc + 32'd4;
                            n_state = cpu0_pkg::S_DECODE;
                        end
                        cpu0_pkg::S_READ: begin
                            n_rdw = {r_data[23:0], r_rbyte};
                            n_state = cpu0_pkg::S_DONE;
                        end
                        default: begin
                            w_rwe = 1'b1;
                            w_rwd = {r_data[23:0], r_rbyte};
                            // A word pop into SP still leaves SP four past the word.
                            if (w_op == cpu0_pkg::OP_POP && r_dst == cpu0_pkg::SP_IDX) begin
                                w_rwd = {r_data[23:0], r_rbyte} + 32'd4;
                            end
                            n_state = cpu0_pkg::S_DONE;
                        end
                    endcase
                end
            end
            cpu0_pkg::S_DECODE: begin
                n_state = cpu0_pkg::S_DONE;
                n_dst   = w_ra;
                n_bcnt  = 2'd0;
                n_word  = 1'b1;
                ea = w_vb + ((w_op[2]) ? w_vc : w_c16);
                case (w_op)
                    cpu0_pkg::OP_LD, cpu0_pkg::OP_LDR, cpu0_pkg::OP_LB,
                    cpu0_pkg::OP_LBR: begin
                        n_addr = ea[AW-1:0];
                        n_word = !w_op[1];
                        n_state = cpu0_pkg::S_MEMRD;
                    end
                    cpu0_pkg::OP_ST, cpu0_pkg::OP_STR, cpu0_pkg::OP_SB,
                    cpu0_pkg::OP_SBR: begin
                        n_addr = ea[AW-1:0];
                        n_data = w_op[1] ? {w_va[7:0], 24'd0} : w_va;
                        n_word = !w_op[1];
                        n_state = cpu0_pkg::S_MEMWR;
                    end
                    cpu0_pkg::OP_PUSH, cpu0_pkg::OP_PSHB: begin
                        ea = r_rf[cpu0_pkg::SP_IDX] - (w_op[1] ? 32'd1 : 32'd4);
                        // Pushing SP itself stores the already lowered SP.
                        push_val = (w_ra == cpu0_pkg::SP_IDX) ? ea : w_va;
                        w_rwe2 = 1'b1;
                        w_rwd2 = ea;
                        n_addr = ea[AW-1:0];
                        n_data = w_op[1] ? {push_val[7:0], 24'd0} : push_val;
                        n_word = !w_op[1];
                        n_state = cpu0_pkg::S_MEMWR;
                    end
                    cpu0_pkg::OP_POP, cpu0_pkg::OP_POPB: begin
                        ea = r_rf[cpu0_pkg::SP_IDX];
                        n_addr = ea[AW-1:0];
                        n_word = !w_op[1];
                        n_state = cpu0_pkg::S_MEMRD;
                        // SP is bumped first; a pop into SP is overwritten later.
                        w_rwe2 = 1'b1;
                        w_rwd2 = ea + (w_op[1] ? 32'd1 : 32'd4);
                    end
                    cpu0_pkg::OP_LDI: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_c16;
                    end
                    cpu0_pkg::OP_CMP: begin
                        cmp = {1'b0, w_va ^ 32'h80000000} - {1'b0, w_vb ^ 32'h80000000};
                        w_rwe = 1'b1;
                        w_rwa = cpu0_pkg::ST_IDX;
                        if (cmp[32]) begin
                            w_rwd = (w_st | 32'h80000000) & 32'hBFFFFFFF;
                        end else if (cmp[31:0] == 32'd0) begin
                            w_rwd = (w_st & 32'h7FFFFFFF) | 32'h40000000;
                        end else begin
                            w_rwd = w_st & 32'h3FFFFFFF;
                        end
                    end
                    cpu0_pkg::OP_MOV: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb;
                    end
                    cpu0_pkg::OP_ADD: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb + w_vc;
                    end
                    cpu0_pkg::OP_SUB: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb - w_vc;
                    end
                    cpu0_pkg::OP_MUL: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb * w_vc;
                    end
                    cpu0_pkg::OP_DIV: begin
                        w_dreq.start = 1'b1;
                        n_state = cpu0_pkg::S_DIV;
                    end
                    cpu0_pkg::OP_AND: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb & w_vc;
                    end
                    cpu0_pkg::OP_OR: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb | w_vc;
                    end
                    cpu0_pkg::OP_XOR: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb ^ w_vc;
                    end
                    cpu0_pkg::OP_ADDI: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb + w_c16;
                    end
                    cpu0_pkg::OP_ROL, cpu0_pkg::OP_ROR: begin
                    end
                    cpu0_pkg::OP_SHL: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = w_vb << w_c5;
                    end
                    cpu0_pkg::OP_SHR: begin
                        w_rwe = 1'b1; w_rwa = w_ra; w_rwd = $signed(w_vb) >>> w_c5;
                    end
                    cpu0_pkg::OP_JEQ: take = w_st[30];
                    cpu0_pkg::OP_JNE: take = !w_st[30];
                    cpu0_pkg::OP_JLT: take = w_st[31] && !w_st[30];
                    cpu0_pkg::OP_JGT: take = !w_st[31] && !w_st[30];
                    cpu0_pkg::OP_JLE: take = w_st[31] ^ w_st[30];
                    cpu0_pkg::OP_JGE: take = !w_st[31];
                    cpu0_pkg::OP_JMP: take = 1'b1;
                    cpu0_pkg::OP_SWI: begin
                        n_swi  = 1'b1;
                        n_code = r_ir[23:0];
                        n_swiv = r_rf[cpu0_pkg::ARG_IDX];
                    end
                    cpu0_pkg::OP_CALL: begin
                        w_rwe = 1'b1; w_rwa = cpu0_pkg::LR_IDX; w_rwd = w_pc;
                        take = 1'b1;
                    end
                    cpu0_pkg::OP_RET, cpu0_pkg::OP_IRET: begin
                        if (r_rf[cpu0_pkg::LR_IDX][31]) begin
                            n_halt = 1'b1;
                        end else begin
                            w_rwe2 = 1'b1;
                            w_rwa2 = cpu0_pkg::PC_IDX;
                            w_rwd2 = r_rf[cpu0_pkg::LR_IDX];
                        end
                    end
                    default: n_ill = 1'b1;
                endcase
                if (take) begin
                    w_rwe2 = 1'b1;
                    w_rwa2 = cpu0_pkg::PC_IDX;
                    w_rwd2 = w_pc + w_c24;
                end
                // Register zero is never written.
                if (w_rwa == 4'd0) begin
                    w_rwe = 1'b0;
                end
            end
            cpu0_pkg::S_DIV: begin
                if (w_drsp.done) begin
                    w_rwe = (r_dst != 4'd0);
                    w_rwd = w_drsp.quotient;
                    n_state = cpu0_pkg::S_DONE;
                end
            end
            cpu0_pkg::S_MEMWR: begin
                w_mwe   = 1'b1;
                w_maddr = r_addr;
                w_mwd   = r_data[31:24];
                n_addr  = r_addr + AW'(1);
                n_data  = {r_data[23:0], 8'd0};
                n_bcnt  = r_bcnt + 2'd1;
                if (!r_word || r_bcnt == 2'd3) begin
                    n_state = cpu0_pkg::S_DONE;
                end
            end
            cpu0_pkg::S_DONE: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_state  = cpu0_pkg::S_IDLE;
                end
            end
            default: n_state = cpu0_pkg::S_IDLE;
        endcase
        if (r_state == cpu0_pkg::S_MEMRD && w_rwa == 4'd0) begin
            w_rwe = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cpu0_pkg::S_IDLE;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
        end
        r_addr <= n_addr;
        r_data <= n_data;
        r_ir   <= n_ir;
        r_bcnt <= n_bcnt;
        r_word <= n_word;
        r_dst  <= n_dst;
        r_ill  <= n_ill;
        r_swi  <= n_swi;
        r_code <= n_code;
        r_swiv <= n_swiv;
        r_rdw  <= n_rdw;
    end

    // The output register is loaded in the done state; the PC is read there
    // after all register writes of the request have landed.
    logic [127:0] r_otd;
    always_ff @(posedge i_clk) begin
        if (r_state == cpu0_pkg::S_DONE && !r_ovalid) begin
            r_otd <= {5'd0, r_rdw, r_swiv, r_code, r_swi, r_ill, r_halt,
                      r_rf[cpu0_pkg::PC_IDX]};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otd;

endmodule

>>> dv/cpu0_instruction_executor_unit_tb.sv
`timescale 1ns / 1ps

// Checks the processor core through its request and result streams. A class
// keeps its own copy of the register file, the memory and the halt flag. It
// works out the expected result of every accepted request, and it compares
// each returned result with the oldest expected one.

module cpu0_instruction_executor_unit_tb;
    import cpu0_pkg::*;

    // One result, laid out as in m_axis_tdata from the highest bit down.
    typedef struct packed {
        logic [31:0] read_word;
        logic [31:0] swi_value;
        logic [23:0] swi_code;
        logic        swi_event;
        logic        illegal_opcode;
        logic        halted;
        logic [31:0] pc_value;
    } t_result;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam int          RUN_LIMIT = 1_000_000;

    // The core's state and the results still due from it.
    class core_scoreboard;
        logic [31:0] regs [16];
        logic [7:0]  mem [MemBytes];
        bit          halt;
        t_result     pending_q [$];
        int          mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            halt = 0;
            mismatches = 0;
        endfunction

        function logic [31:0] rd8(logic [31:0] a);
            return {24'h0, mem[a[MemAddrW-1:0]]};
        endfunction

        function void wr8(logic [31:0] a, logic [31:0] v);
            mem[a[MemAddrW-1:0]] = v[7:0];
        endfunction

        function logic [31:0] rd32(logic [31:0] a);
            return {mem[a[MemAddrW-1:0]], mem[(a + 1) % MemBytes],
                    mem[(a + 2) % MemBytes], mem[(a + 3) % MemBytes]};
        endfunction

        function void wr32(logic [31:0] a, logic [31:0] v);
            wr8(a, v >> 24);
            wr8(a + 1, v >> 16);
            wr8(a + 2, v >> 8);
            wr8(a + 3, v);
        endfunction

        // Signed quotient, zero for a zero divisor; the most negative value
        // over minus one wraps back to itself.
        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ua, ub, q;
            if (b == 0) return '0;
            ua = a[31] ? -a : a;
            ub = b[31] ? -b : b;
            q = ua / ub;
            return (a[31] ^ b[31]) ? -q : q;
        endfunction

        function void run_instruction(inout t_result r);
            logic [31:0] ir, c24, c16, addr, raddr, a, b;
            logic [7:0]  op;
            logic [3:0]  ra, rb, rc;
            logic [4:0]  c5;
            logic        n, z, take;
            take = 0;
            regs[0] = '0;
            ir = rd32(regs[PcIndex]);
            regs[PcIndex] += 4;
            op = ir[31:24];
            ra = ir[23:20];
            rb = ir[19:16];
            rc = ir[15:12];
            c24 = {{8{ir[23]}}, ir[23:0]};
            c16 = {{16{ir[15]}}, ir[15:0]};
            c5 = ir[4:0];
            addr = regs[rb] + c16;
            raddr = regs[rb] + regs[rc];
            n = regs[StatusIndex][31];
            z = regs[StatusIndex][30];
            case (op)
                OP_LD:   regs[ra] = rd32(addr);
                OP_ST:   wr32(addr, regs[ra]);
                OP_LB:   regs[ra] = rd8(addr);
                OP_SB:   wr8(addr, regs[ra]);
                OP_LDR:  regs[ra] = rd32(raddr);
                OP_STR:  wr32(raddr, regs[ra]);
                OP_LBR:  regs[ra] = rd8(raddr);
                OP_SBR:  wr8(raddr, regs[ra]);
                OP_LDI:  regs[ra] = c16;
                OP_CMP: begin
                    a = regs[ra] ^ SIGN_BIT;
                    b = regs[rb] ^ SIGN_BIT;
                    if (a > b) begin
                        regs[StatusIndex][31:30] = 2'b00;
                    end else if (a < b) begin
                        regs[StatusIndex][31:30] = 2'b10;
                    end else begin
                        regs[StatusIndex][31:30] = 2'b01;
                    end
                end
                OP_MOV:  regs[ra] = regs[rb];
                OP_ADD:  regs[ra] = regs[rb] + regs[rc];
                OP_SUB:  regs[ra] = regs[rb] - regs[rc];
                OP_MUL:  regs[ra] = regs[rb] * regs[rc];
                OP_DIV:  regs[ra] = quotient(regs[rb], regs[rc]);
                OP_AND:  regs[ra] = regs[rb] & regs[rc];
                OP_OR:   regs[ra] = regs[rb] | regs[rc];
                OP_XOR:  regs[ra] = regs[rb] ^ regs[rc];
                OP_ADDI: regs[ra] = regs[rb] + c16;
                OP_ROL, OP_ROR: ;
                OP_SHL:  regs[ra] = regs[rb] << c5;
                OP_SHR:  regs[ra] = $signed(regs[rb]) >>> c5;
                OP_JEQ:  take = z;
                OP_JNE:  take = !z;
                OP_JLT:  take = n && !z;
                OP_JGT:  take = !n && !z;
                OP_JLE:  take = n ^ z;
                OP_JGE:  take = !n;
                OP_JMP:  take = 1;
                OP_SWI: begin
                    r.swi_event = 1;
                    r.swi_code = ir[23:0];
                    r.swi_value = regs[ArgIndex];
                end
                OP_CALL: begin
                    regs[LrIndex] = regs[PcIndex];
                    regs[PcIndex] += c24;
                end
                OP_RET, OP_IRET: begin
                    if (regs[LrIndex][31]) halt = 1;
                    else regs[PcIndex] = regs[LrIndex];
                end
                OP_PUSH: begin
                    regs[SpIndex] -= 4;
                    wr32(regs[SpIndex], regs[ra]);
                end
                OP_POP: begin
                    regs[ra] = rd32(regs[SpIndex]);
                    regs[SpIndex] += 4;
                end
                OP_PSHB: begin
                    regs[SpIndex] -= 1;
                    wr8(regs[SpIndex], regs[ra]);
                end
                OP_POPB: begin
                    regs[ra] = rd8(regs[SpIndex]);
                    regs[SpIndex] += 1;
                end
                default: r.illegal_opcode = 1;
            endcase
            if (take) regs[PcIndex] += c24;
        endfunction

        // Called for every request the core accepts.
        function void note_request(logic [1:0] action, logic [11:0] address,
                                   logic [31:0] data);
            t_result r;
            r = '0;
            case (action)
                ACT_WRITE: wr32({20'h0, address}, data);
                ACT_EXEC:  if (!halt) run_instruction(r);
                ACT_READ:  r.read_word = rd32({20'h0, address});
                default: ;
            endcase
            r.pc_value = regs[PcIndex];
            r.halted = halt;
            pending_q.push_back(r);
        endfunction

        // Called for every result the core hands out.
        function void check_result(logic [127:0] tdata);
            t_result got, want;
            got = t_result'(tdata[$bits(t_result)-1:0]);
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.pc_value !== want.pc_value || got.halted !== want.halted ||
                got.illegal_opcode !== want.illegal_opcode ||
                got.swi_event !== want.swi_event || got.swi_code !== want.swi_code ||
                got.swi_value !== want.swi_value ||
                got.read_word !== want.read_word) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: pc %h/%h halt %b/%b ill %b/%b swi %b/%b",
                             want.pc_value, got.pc_value, want.halted, got.halted,
                             want.illegal_opcode, got.illegal_opcode,
                             want.swi_event, got.swi_event);
                    $display("  swi_code %h/%h swi_value %h/%h read %h/%h (exp/act)",
                             want.swi_code, got.swi_code, want.swi_value,
                             got.swi_value, want.read_word, got.read_word);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    core_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  want_hold;
    int  hold_left;
    int  cycle_count;

    logic [7:0] legal_ops [] = '{OP_LD, OP_ST, OP_LB, OP_SB, OP_LDR, OP_STR,
        OP_LBR, OP_SBR, OP_LDI, OP_CMP, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
        OP_AND, OP_OR, OP_XOR, OP_ADDI, OP_ROL, OP_ROR, OP_SHL, OP_SHR, OP_JEQ,
        OP_JNE, OP_JLT, OP_JGT, OP_JLE, OP_JGE, OP_JMP, OP_SWI, OP_CALL, OP_RET,
        OP_IRET, OP_PUSH, OP_POP, OP_PSHB, OP_POPB};

    cpu0_instruction_executor_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // The sink side: random stalls, plus one long hold-off on demand so the
    // core backs up and stops taking requests.
    initial begin
        m_axis_tready = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (want_hold) begin
                hold_left = 400;
                want_hold = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one request, with random idle cycles ahead of it, and waits
    // until the core takes it.
    task automatic send(logic [1:0] action, logic [11:0] address, logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, data, address, action};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(action, address, data);
    endtask

    // Places an instruction at the current program counter and runs it.
    task automatic run(logic [31:0] instr);
        send(ACT_WRITE, sb.regs[PcIndex][11:0], instr);
        send(ACT_EXEC, '0, '0);
    endtask

    function automatic logic [31:0] encode(logic [7:0] op, logic [3:0] ra,
                                           logic [3:0] rb, logic [15:0] low);
        return {op, ra, rb, low};
    endfunction

    // A return with a negative link register would stop the core for good;
    // that case is kept for the end of the run.
    function automatic bit would_halt(logic [31:0] instr);
        return (instr[31:24] == OP_RET || instr[31:24] == OP_IRET) &&
               sb.regs[LrIndex][31];
    endfunction

    function automatic logic [31:0] random_instr();
        logic [7:0]  op;
        logic [31:0] w;
        if ($urandom_range(19) == 0) begin
            do op = 8'($urandom); while (op inside {legal_ops});
        end else begin
            op = legal_ops[$urandom_range(legal_ops.size() - 1)];
        end
        w = {op, 24'($urandom)};
        // Short jumps most of the time, so the program stays near its code.
        if (op inside {OP_JEQ, OP_JNE, OP_JLT, OP_JGT, OP_JLE, OP_JGE, OP_JMP, OP_CALL}
            && $urandom_range(3) != 0)
            w[23:0] = 24'($signed($urandom_range(64)) - 32);
        if (would_halt(w)) w[31:24] = OP_ROL;
        return w;
    endfunction

    task automatic random_phase(int count);
        int          k;
        logic [31:0] w;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(99)) inside
                [0:69]: run(random_instr());
                [70:79]: begin
                    w = sb.rd32(sb.regs[PcIndex]);
                    if (!would_halt(w)) send(ACT_EXEC, 12'($urandom), $urandom);
                end
                [80:89]: send(ACT_WRITE, 12'($urandom), $urandom);
                [90:97]: send(ACT_READ, 12'($urandom), $urandom);
                default: send(2'd3, 12'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        int a;
        int waited;
        sb = new();
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        want_hold = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Memory extremes: a word that wraps around the top of memory, all
        // ones, and the unused action that changes nothing.
        send(ACT_WRITE, 12'hFFE, 32'hDEAD_BEEF);
        send(ACT_READ, 12'hFFE, '0);
        send(ACT_WRITE, 12'hFFC, 32'hFFFF_FFFF);
        send(ACT_READ, 12'hFFC, '0);
        send(2'd3, 12'hFFF, 32'hFFFF_FFFF);

        // Define every byte so that no later access reads unwritten memory.
        for (a = 0; a < MemBytes; a += 4) send(ACT_WRITE, 12'(a), $urandom);

        // Directed instructions: divide by zero, most negative over minus
        // one, a compare and a conditional jump, interrupt, call and return,
        // push and pop, and an unsupported opcode.
        run(encode(OP_LDI, 4'd1, 4'd0, 16'hFFFF));
        run(encode(OP_LDI, 4'd6, 4'd0, 16'h0001));
        run(encode(OP_SHL, 4'd2, 4'd6, 16'h001F));
        run(encode(OP_DIV, 4'd3, 4'd2, 16'h1000));
        run(encode(OP_DIV, 4'd4, 4'd2, 16'h0000));
        run(encode(OP_CMP, 4'd2, 4'd1, 16'h0000));
        run(encode(OP_JLE, 4'd0, 4'd0, 16'h0008));
        run({OP_SWI, 24'h80_0001});
        run({OP_CALL, 24'h00_0010});
        run(encode(OP_RET, 4'd0, 4'd0, 16'h0000));
        run(encode(OP_PUSH, 4'd2, 4'd0, 16'h0000));
        run(encode(OP_POP, 4'd5, 4'd0, 16'h0000));
        run(32'hFF00_0000);

        // Random traffic under the different idling patterns.
        random_phase(45);
        send_idle_pct = 74;
        random_phase(45);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        @(negedge i_clk);
        want_hold = 1;
        random_phase(45);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        random_phase(40);

        // Stop the core: a return with a negative link register, then an
        // instruction that must do nothing, then a memory read that still works.
        run(encode(OP_LDI, LR_IDX, 4'd0, 16'h8000));
        run(encode(OP_RET, 4'd0, 4'd0, 16'h0000));
        send(ACT_EXEC, '0, '0);
        send(ACT_READ, 12'h000, '0);

        @(negedge i_clk);
        s_axis_tvalid <= 0;
        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> cpu0_instruction_executor_unit.f
hw/rtl/cpu0_pkg.sv
hw/rtl/cpu0_divider.sv
hw/rtl/cpu0_instruction_executor_unit.sv
dv/cpu0_instruction_executor_unit_tb.sv
